>>> hw/rtl/lph_pkg.sv
package lph_pkg;

  localparam int MaxTypes  = 16;
  localparam int MaxOrders = 32;
  localparam int TypeW     = $clog2(MaxTypes);
  localparam int OrdW      = $clog2(MaxOrders);
  localparam int CntW      = $clog2(MaxOrders + 1);
  localparam int AddrW     = TypeW + OrdW;
  localparam int Depth     = MaxTypes * MaxOrders;
  localparam int SumW      = 48;
  localparam int NumW      = 38;
  localparam int QDepth    = 2;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCntW     = $clog2(QDepth + 1);

  localparam logic signed [31:0] OneQ30 = 32'sh4000_0000;
  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  localparam logic [0:0] REG_INV_BETA    = 1'b0;
  localparam logic [0:0] REG_ORDER_COUNT = 1'b1;

  typedef enum logic [1:0] {
    CMD_ACC    = 2'd0,
    CMD_SIGN   = 2'd1,
    CMD_RD_TBL = 2'd2,
    CMD_RD_SUM = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [3:0]         type_index;
    logic [31:0]        tau_later;
    logic [31:0]        tau_earlier;
    logic signed [31:0] weight;
    logic [4:0]         order_index;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t ent;
  } fe_q_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } be_stat_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MAP, ST_MAPX, ST_START, ST_NUM, ST_DIV, ST_CLAMP,
    ST_WMUL, ST_RND, ST_ADD, ST_SIGN, ST_RDWAIT, ST_EMIT
  } be_state_t;

  function automatic logic signed [SumW-1:0] sat_sum(input logic signed [SumW:0] s);
    logic ovf;
    ovf = s[SumW] != s[SumW-1];
    if (ovf) begin
      sat_sum = s[SumW] ? SumMin : SumMax;
    end else begin
      sat_sum = s[SumW-1:0];
    end
  endfunction

endpackage

>>> hw/rtl/lph_front.sv
module lph_front
  import lph_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  entry_t   in_ent,
  input  be_stat_t stat,
  output fe_q_t    q
);

  entry_t           buf_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] cnt_r;
  logic             push;

  assign in_tready = (cnt_r != QCntW'(QDepth)) && !stat.clearing;
  assign push      = in_tvalid && in_tready;
  assign q.valid   = cnt_r != '0;
  assign q.ent     = buf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= in_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (stat.pop) begin
        rd_ptr_r <= (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QCntW'(push) - QCntW'(stat.pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCntW'(QDepth)) else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pop |-> cnt_r != '0) else $error("pop from empty queue");
  a_no_push_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !push) else $error("transaction taken during clear");

endmodule

>>> hw/rtl/lph_back.sv
module lph_back
  import lph_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  fe_q_t             q,
  output be_stat_t          stat,
  input  logic [31:0]       inv_beta,
  input  logic [5:0]        order_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [SumW-1:0] out_value,
  output logic              out_sat
);

  be_state_t state_r, state_nxt;

  logic [SumW:0]          mem [Depth];
  logic [SumW:0]          rd_q_r;
  logic                   we;
  logic [AddrW-1:0]       wa, ra;
  logic [SumW:0]          wd;
  logic [AddrW-1:0]       clr_cnt_r;

  entry_t                 ent_r;
  logic [CntW-1:0]        n_r, l_r;
  logic [5:0]             div_cnt_r;
  logic [63:0]            mag_r;
  logic                   pos_r;
  logic signed [31:0]     x_r, p_r, pp_r, pp2_r;
  logic signed [63:0]     prod_r;
  logic [NumW-1:0]        dvd_r;
  logic [6:0]             rem_r;
  logic                   neg_r;
  logic signed [SumW-1:0] delta_r;
  logic signed [SumW-1:0] total_r;
  logic                   total_mark_r;

  logic                   out_valid_r, out_sat_r;
  logic signed [SumW-1:0] out_value_r;

  logic                   emit_ok;
  logic [CntW-1:0]        n_new;
  logic [55:0]            t_map;
  logic [63:0]            pm_abs;
  logic [33:0]            xp_mag;
  logic signed [31:0]     xp;
  logic [6:0]             coef_a, coef_b;
  logic signed [39:0]     ta, tb, num40, num_abs;
  logic [6:0]             div_t;
  logic                   div_ge;
  logic [63:0]            wp_abs;
  logic [37:0]            wp_mag;
  logic signed [SumW:0]   add_s, sign_s;
  logic signed [31:0]     p_clamp;

  assign stat.pop      = (state_r == ST_IDLE) && q.valid;
  assign stat.clearing = state_r == ST_CLEAR;
  assign emit_ok       = !out_valid_r || out_ready;
  assign n_new = (order_count > 6'(MaxOrders)) ? CntW'(MaxOrders) : CntW'(order_count);

  // datapath helpers
  always_comb begin
    t_map   = {1'b0, mag_r[63:9]} + 56'(mag_r[8]);
    pm_abs  = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
    xp_mag  = 34'((pm_abs + 64'(1) * (64'(1) << 29)) >> 30);
    xp      = prod_r[63] ? -32'(signed'(xp_mag)) : 32'(signed'(xp_mag));
    coef_a  = 7'({l_r, 1'b0}) - 7'd1;
    coef_b  = 7'(l_r) - 7'd1;
    ta      = $signed({1'b0, coef_a}) * xp;
    tb      = $signed({1'b0, coef_b}) * pp2_r;
    num40   = ta - tb;
    num_abs = num40[39] ? -num40 : num40;
    div_t   = {rem_r[5:0], dvd_r[NumW-1]};
    div_ge  = div_t >= 7'(l_r);
    p_clamp = (dvd_r > NumW'(OneQ30)) ? OneQ30 : 32'(dvd_r[31:0]);
    wp_abs  = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
    wp_mag  = 38'((wp_abs + (64'(1) << 25)) >> 26);
    add_s   = $signed({rd_q_r[SumW-1], rd_q_r[SumW-1:0]}) + (SumW+1)'(delta_r);
    sign_s  = (SumW+1)'(total_r) + (SumW+1)'($signed({ent_r.weight, 4'b0000}));
  end

  // table memory
  assign ra = (ent_r.cmd == CMD_RD_TBL) ? {ent_r.type_index, ent_r.order_index}
                                        : {ent_r.type_index, l_r[OrdW-1:0]};
  always_comb begin
    we = 1'b0;
    wa = clr_cnt_r;
    wd = '0;
    if (state_r == ST_CLEAR) begin
      we = 1'b1;
    end else if (state_r == ST_ADD) begin
      we = 1'b1;
      wa = ra;
      wd = {rd_q_r[SumW] | (add_s[SumW] != add_s[SumW-1]), sat_sum(add_s)};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q_r <= mem[ra];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_cnt_r == AddrW'(Depth - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (q.valid) begin
          unique case (q.ent.cmd)
            CMD_ACC:    state_nxt = (n_new == '0) ? ST_IDLE : ST_MAP;
            CMD_SIGN:   state_nxt = ST_SIGN;
            CMD_RD_TBL: state_nxt = ST_RDWAIT;
            CMD_RD_SUM: state_nxt = ST_EMIT;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MAP:    state_nxt = ST_MAPX;
      ST_MAPX:   state_nxt = ST_START;
      ST_START:  state_nxt = (l_r < CntW'(2)) ? ST_WMUL : ST_NUM;
      ST_NUM:    state_nxt = ST_DIV;
      ST_DIV:    if (div_cnt_r == 6'(NumW - 1)) state_nxt = ST_CLAMP;
      ST_CLAMP:  state_nxt = ST_WMUL;
      ST_WMUL:   state_nxt = ST_RND;
      ST_RND:    state_nxt = ST_ADD;
      ST_ADD:    state_nxt = (l_r + 1'b1 == n_r) ? ST_IDLE : ST_START;
      ST_SIGN:   state_nxt = ST_IDLE;
      ST_RDWAIT: state_nxt = ST_EMIT;
      ST_EMIT:   if (emit_ok) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r    <= '0;
      total_r      <= '0;
      total_mark_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (state_r == ST_SIGN) begin
        total_r <= sat_sum(sign_s);
        if (sign_s[SumW] != sign_s[SumW-1]) begin
          total_mark_r <= 1'b1;
        end
      end
      if (state_r == ST_EMIT && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        ent_r <= q.ent;
        n_r   <= n_new;
        l_r   <= '0;
        pp_r  <= '0;
        pp2_r <= '0;
      end
      ST_MAP: begin
        pos_r <= ent_r.tau_later > ent_r.tau_earlier;
        mag_r <= 64'(ent_r.tau_later - ent_r.tau_earlier) * 64'(inv_beta);
      end
      ST_MAPX: begin
        if (!pos_r) begin
          x_r <= -OneQ30;
        end else if (t_map >= (56'(1) << 31)) begin
          x_r <= OneQ30;
        end else begin
          x_r <= signed'(t_map[31:0]) - OneQ30;
        end
      end
      ST_START: begin
        if (l_r == '0) begin
          p_r <= OneQ30;
        end else if (l_r == CntW'(1)) begin
          p_r <= x_r;
        end else begin
          prod_r <= x_r * pp_r;
        end
      end
      ST_NUM: begin
        neg_r     <= num40[39];
        dvd_r     <= num_abs[NumW-1:0] + NumW'(l_r >> 1);
        rem_r     <= '0;
        div_cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r     <= div_ge ? div_t - 7'(l_r) : div_t;
        dvd_r     <= {dvd_r[NumW-2:0], div_ge};
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      ST_CLAMP:  p_r <= neg_r ? -p_clamp : p_clamp;
      ST_WMUL:   prod_r <= ent_r.weight * p_r;
      ST_RND:    delta_r <= prod_r[63] ? -SumW'(signed'(wp_mag)) : SumW'(signed'(wp_mag));
      ST_ADD: begin
        pp2_r <= pp_r;
        pp_r  <= p_r;
        l_r   <= l_r + 1'b1;
      end
      ST_EMIT: begin
        if (emit_ok) begin
          if (ent_r.cmd == CMD_RD_TBL) begin
            out_value_r <= rd_q_r[SumW-1:0];
            out_sat_r   <= rd_q_r[SumW];
          end else begin
            out_value_r <= total_r;
            out_sat_r   <= total_mark_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_sat   = out_sat_r;

  a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WMUL |-> l_r < n_r) else $error("order index past count");
  a_p_unit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLAMP |=> (p_r <= OneQ30 && p_r >= -OneQ30))
    else $error("polynomial value out of unit range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(out_ready)) else $error("result dropped");

endmodule

>>> hw/rtl/legendre_projection_histogram_top.sv
// legendre projection histogram
// in_* channel: one command per transaction, kind in in_tuser (0 accumulate
// vertex, 1 add sign, 2 read table entry, 3 read sign total), operands in
// in_tdata. out_* channel: one result per read command, none for the others.
// cfg_* channel: index 0 writes inv_beta, index 1 writes order_count; always
// ready, write only while the block is idle.
// commands pass through a two-entry queue to a sequencer that owns the table
// memory (one read and one write port), so the input keeps taking commands
// while the sequencer works or a result waits on the output register.
// accumulate: each recurrence step from order 2 up runs the serial divider
// (one quotient bit per cycle, 38 bits). add sign saturates into the sign
// total in ST_SIGN. a table read passes ST_RDWAIT; both reads load the output
// register in ST_EMIT. after reset a clearing pass zeroes the 512-entry table;
// in_tready stays low until it ends. a stalled out_tready holds the result
// and the sequencer waits in its result step; the queue fills, then in_tready drops.
module legendre_projection_histogram_top
  import lph_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,  // type_index, tau_later, tau_earlier, weight, order_index
  input  logic [1:0]   in_tuser,  // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [55:0]  out_tdata, // read_value, saturated
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [31:0]            inv_beta_r;
  logic [5:0]             order_count_r;
  entry_t                 in_ent;
  fe_q_t                  q;
  be_stat_t               stat;
  logic signed [SumW-1:0] value;
  logic                   sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_beta_r    <= 32'd16777216;
      order_count_r <= 6'(MaxOrders);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_INV_BETA:    inv_beta_r    <= cfg_data;
        REG_ORDER_COUNT: order_count_r <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ent.cmd         = cmd_t'(in_tuser);
  assign in_ent.type_index  = in_tdata[3:0];
  assign in_ent.tau_later   = in_tdata[35:4];
  assign in_ent.tau_earlier = in_tdata[67:36];
  assign in_ent.weight      = signed'(in_tdata[99:68]);
  assign in_ent.order_index = in_tdata[104:100];

  lph_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_ent    (in_ent),
    .stat      (stat),
    .q         (q)
  );

  lph_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q           (q),
    .stat        (stat),
    .inv_beta    (inv_beta_r),
    .order_count (order_count_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_value   (value),
    .out_sat     (sat)
  );

  assign out_tdata = {7'd0, sat, value};

endmodule

>>> bench/tb.sv
module tb;
  import lph_pkg::*;

  localparam longint Unit      = 64'sd1 << 30;
  localparam longint SumTop    = (64'sd1 <<< 47) - 1;
  localparam longint SumBottom = -(64'sd1 <<< 47);
  localparam int     Settle    = 5000;
  localparam int     WdogLimit = 40000;

  typedef struct {
    logic [47:0] value;
    logic        sat;
  } readback_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [55:0]  out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [0:0]   cfg_index;
  logic [31:0]  cfg_data;

  legendre_projection_histogram_top dut (.*);

  entry_t    pending[$];
  readback_t readbacks[$];

  longint      coef_sum[Depth];
  bit          coef_sat[Depth + 1];
  longint      sign_sum;
  logic [31:0] beta_recip;
  logic [5:0]  num_orders;

  int  errors;
  int  wdog;
  bit  in_fire;
  bit  out_fire;
  int  tx_gap;
  int  rx_gap;
  int  rx_hold;
  bit  hold_req;
  bit  no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint round_shift(longint v, int s);
    longint half;
    half = 64'sd1 <<< (s - 1);
    if (v < 0) return -((-v + half) >>> s);
    return (v + half) >>> s;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint unit_clamp(longint v);
    if (v > Unit) return Unit;
    if (v < -Unit) return -Unit;
    return v;
  endfunction

  function automatic void sum_add(ref longint acc, ref bit mark, input longint delta);
    longint r;
    r = acc + delta;
    if (r > SumTop) begin
      r = SumTop;
      mark = 1'b1;
    end
    if (r < SumBottom) begin
      r = SumBottom;
      mark = 1'b1;
    end
    acc = r;
  endfunction

  function automatic longint time_to_x(logic [31:0] later, logic [31:0] earlier);
    logic [63:0] mag;
    logic [63:0] t;
    if (later <= earlier) return -Unit;
    mag = {32'd0, later - earlier} * {32'd0, beta_recip};
    t = (mag >> 9) + ((mag >> 8) & 64'd1);
    if (t >= 64'h8000_0000) return Unit;
    return unit_clamp(longint'(t) - Unit);
  endfunction

  function automatic void add_vertex(logic [3:0] row, logic [31:0] later,
                                     logic [31:0] earlier, longint w);
    int     n;
    int     idx;
    longint x;
    longint p;
    longint p1;
    longint p2;
    longint num;
    n = (num_orders > MaxOrders) ? MaxOrders : num_orders;
    x = time_to_x(later, earlier);
    p = 0;
    p1 = 0;
    p2 = 0;
    if (row >= MaxTypes) return;
    for (int l = 0; l < n; l++) begin
      if (l == 0) p = Unit;
      else if (l == 1) p = x;
      else begin
        num = longint'(2 * l - 1) * round_shift(x * p1, 30) - longint'(l - 1) * p2;
        p = unit_clamp(round_div(num, longint'(l)));
      end
      idx = row * MaxOrders + l;
      sum_add(coef_sum[idx], coef_sat[idx], round_shift(w * p, 26));
      p2 = p1;
      p1 = p;
    end
  endfunction

  function automatic void predict(cmd_t c, logic [111:0] d);
    logic [3:0]  row;
    logic [4:0]  ord;
    longint      w;
    readback_t   rb;
    int          idx;
    row = d[3:0];
    ord = d[104:100];
    w = longint'($signed(d[99:68]));
    case (c)
      CMD_ACC: add_vertex(row, d[35:4], d[67:36], w);
      CMD_SIGN: sum_add(sign_sum, coef_sat[Depth], w * 16);
      CMD_RD_TBL: begin
        if (row < MaxTypes && ord < MaxOrders) begin
          idx = row * MaxOrders + ord;
          rb.value = coef_sum[idx][47:0];
          rb.sat = coef_sat[idx];
        end else begin
          rb.value = '0;
          rb.sat = 1'b0;
        end
        readbacks.push_back(rb);
      end
      default: begin
        rb.value = sign_sum[47:0];
        rb.sat = coef_sat[Depth];
        readbacks.push_back(rb);
      end
    endcase
  endfunction

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 16);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict(cmd_t'(in_tuser), in_tdata);
        in_fire = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_INV_BETA) beta_recip = cfg_data;
        else num_orders = cfg_data[5:0];
      end
      if (out_tvalid && out_tready) begin
        out_fire = 1'b1;
        if (readbacks.size() == 0) begin
          errors++;
          $display("%0t: unexpected result expected none actual %h", $time, out_tdata);
        end else begin
          readback_t rb;
          rb = readbacks.pop_front();
          if (out_tdata[47:0] !== rb.value) begin
            errors++;
            $display("%0t: read_value expected %h actual %h", $time, rb.value,
                     out_tdata[47:0]);
          end
          if (out_tdata[48] !== rb.sat) begin
            errors++;
            $display("%0t: saturated expected %b actual %b", $time, rb.sat, out_tdata[48]);
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        wdog = 0;
      else
        wdog++;
      if (wdog >= WdogLimit) begin
        $display("legendre_projection_histogram_top verification failed");
        $finish;
      end
    end
  end

  // sender
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_fire)) begin
      in_fire = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
        entry_t e;
        e = pending.pop_front();
        in_tdata <= {7'd0, e.order_index, e.weight, e.tau_earlier, e.tau_later, e.type_index};
        in_tuser <= e.cmd;
        in_tvalid <= 1'b1;
        tx_gap = draw_gap();
        if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_req) begin
      rx_hold = 400;
      hold_req = 1'b0;
    end
    if (out_fire) begin
      out_fire = 1'b0;
      rx_gap = draw_gap();
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void push(cmd_t c, logic [3:0] row, logic [31:0] later,
                               logic [31:0] earlier, logic [31:0] w, logic [4:0] ord);
    entry_t e;
    e.cmd = c;
    e.type_index = row;
    e.tau_later = later;
    e.tau_earlier = earlier;
    e.weight = w;
    e.order_index = ord;
    pending.push_back(e);
  endfunction

  function automatic void push_random(int count);
    int          k;
    cmd_t        c;
    logic [31:0] earlier;
    logic [31:0] later;
    logic [31:0] w;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      c = (k < 35) ? CMD_ACC : (k < 55) ? CMD_SIGN : (k < 90) ? CMD_RD_TBL : CMD_RD_SUM;
      earlier = $urandom();
      case ($urandom_range(0, 3))
        0: later = $urandom();
        1: later = earlier + $urandom_range(0, 32'h0004_0000);
        2: later = earlier - $urandom_range(0, 255);
        default: later = earlier + ($urandom() >> $urandom_range(0, 31));
      endcase
      case ($urandom_range(0, 5))
        0: w = 32'h7fff_ffff;
        1: w = 32'h8000_0000;
        default: w = $urandom();
      endcase
      push(c, 4'($urandom()), later, earlier, w, 5'($urandom()));
    end
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (pending.size() != 0 || in_tvalid || readbacks.size() != 0);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    wdog = 0;
    in_fire = 0;
    out_fire = 0;
    tx_gap = 0;
    rx_gap = 0;
    rx_hold = 0;
    hold_req = 0;
    no_idle = 0;
    foreach (coef_sum[i]) coef_sum[i] = 0;
    foreach (coef_sat[i]) coef_sat[i] = 0;
    sign_sum = 0;
    beta_recip = 32'h0100_0000;
    num_orders = 6'd32;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // corner items at reset settings
    push(CMD_ACC, 4'd0, 32'd5, 32'd9, 32'h7fff_ffff, 5'd0);
    push(CMD_ACC, 4'd0, 32'd9, 32'd9, 32'h8000_0000, 5'd0);
    push(CMD_ACC, 4'd15, 32'hffff_ffff, 32'd0, 32'h7fff_ffff, 5'd31);
    push(CMD_ACC, 4'd1, 32'h0000_8000, 32'd0, 32'h1000_0000, 5'd0);
    push(CMD_ACC, 4'd2, 32'h0001_0000, 32'h0000_0000, 32'hf000_0000, 5'd0);
    push(CMD_RD_TBL, 4'd0, 32'd0, 32'd0, 32'd0, 5'd0);
    push(CMD_RD_TBL, 4'd0, 32'd0, 32'd0, 32'd0, 5'd31);
    push(CMD_RD_TBL, 4'd15, 32'd0, 32'd0, 32'd0, 5'd31);
    push(CMD_RD_TBL, 4'd15, 32'd0, 32'd0, 32'd0, 5'd1);
    push(CMD_RD_TBL, 4'd1, 32'd0, 32'd0, 32'd0, 5'd7);
    push(CMD_RD_TBL, 4'd2, 32'd0, 32'd0, 32'd0, 5'd2);
    push(CMD_SIGN, 4'd0, 32'd0, 32'd0, 32'h7fff_ffff, 5'd0);
    push(CMD_SIGN, 4'd0, 32'd0, 32'd0, 32'h8000_0000, 5'd0);
    push(CMD_SIGN, 4'd0, 32'd0, 32'd0, 32'h8000_0000, 5'd0);
    push(CMD_RD_SUM, 4'hf, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 5'h1f);
    push(CMD_RD_TBL, 4'd3, 32'd0, 32'd0, 32'd0, 5'd0);
    wait_idle();

    write_reg(REG_INV_BETA, 32'd1);
    write_reg(REG_ORDER_COUNT, 32'd1);
    push_random(90);
    wait_idle();

    write_reg(REG_INV_BETA, 32'hffff_ffff);
    write_reg(REG_ORDER_COUNT, 32'd0);
    push(CMD_ACC, 4'd4, 32'd100, 32'd0, 32'h7fff_ffff, 5'd0);
    push(CMD_RD_TBL, 4'd4, 32'd0, 32'd0, 32'd0, 5'd0);
    push_random(70);
    wait_idle();

    write_reg(REG_ORDER_COUNT, 32'd63);
    write_reg(REG_INV_BETA, $urandom());
    push_random(100);
    wait_idle();

    write_reg(REG_ORDER_COUNT, 32'd2);
    write_reg(REG_INV_BETA, 32'h0100_0000 >> $urandom_range(0, 8));
    push_random(120);
    wait_idle();

    write_reg(REG_ORDER_COUNT, 32'($urandom_range(3, 12)));
    write_reg(REG_INV_BETA, $urandom());
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) push(CMD_RD_SUM, 4'd0, 32'd0, 32'd0, 32'd0, 5'd0);
    push_random(150);
    wait_idle();

    if (errors == 0) begin
      $display("legendre_projection_histogram_top verification clean");
    end else begin
      $display("legendre_projection_histogram_top verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/lph_pkg.sv
hw/rtl/lph_front.sv
hw/rtl/lph_back.sv
hw/rtl/legendre_projection_histogram_top.sv
bench/tb.sv
